@@ design/glq_pkg.sv @@
// glq_pkg: types, constants and helper functions for glyph_quad_layout
// no dependencies; imported by every module of the block except the generic ram

package glq_pkg;

  localparam int GLQ_ENTRIES_DEF   = 128;
  localparam int GLQ_FALLBACK_CODE = 63;
  localparam int GLQ_CFG_W         = 17;
  localparam int GLQ_PROD_W        = 44;
  localparam int GLQ_MUL_W         = 22;

  localparam logic [16:0] GLQ_INV_EM_RST = 17'd2048;
  localparam logic [15:0] GLQ_ASC_RST    = 16'd0;
  localparam logic [16:0] GLQ_NDC_X_RST  = 17'd102;
  localparam logic [16:0] GLQ_NDC_Y_RST  = 17'd182;

  localparam logic signed [GLQ_PROD_W-1:0] GLQ_NDC_ONE = 44'sd16384;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_CHAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_INV_EM   = 2'd0,
    CFG_ASCENDER = 2'd1,
    CFG_NDC_X    = 2'd2,
    CFG_NDC_Y    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_SCALE = 4'd1,
    OP_ASC   = 4'd2,
    OP_XO    = 4'd3,
    OP_YO    = 4'd4,
    OP_W     = 4'd5,
    OP_H     = 4'd6,
    OP_ADV   = 4'd7,
    OP_NX0   = 4'd8,
    OP_NX1   = 4'd9,
    OP_NY0   = 4'd10,
    OP_NY1   = 4'd11
  } op_t;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic        [7:0]  code;
    logic signed [19:0] start_x;
    logic signed [19:0] start_y;
    logic        [11:0] size;
    logic        [31:0] color;
    logic signed [15:0] advance;
    logic signed [15:0] xoffset;
    logic signed [15:0] yoffset;
    logic        [14:0] width;
    logic        [14:0] height;
    logic        [63:0] uv_rect;
  } glq_in_t;

  typedef struct packed {
    logic signed [15:0] x_ndc;
    logic signed [15:0] y_ndc;
    logic        [15:0] tex_u;
    logic        [15:0] tex_v;
    logic        [31:0] vertex_color;
    logic        [15:0] vertex_index;
    logic               last;
  } glq_out_t;

  typedef struct packed {
    logic signed [15:0] advance;
    logic signed [15:0] xoffset;
    logic signed [15:0] yoffset;
    logic        [14:0] width;
    logic        [14:0] height;
    logic        [63:0] uv_rect;
  } glq_glyph_t;

  typedef struct packed {
    logic       accept;
    op_t        op;
    logic       miss_adv;
    logic       emit;
    logic [1:0] vtx;
  } glq_cmd_t;

  typedef struct packed {
    logic found;
    logic empty;
    logic out_free;
  } glq_sts_t;

  function automatic logic signed [19:0] sat20(input logic signed [GLQ_PROD_W-1:0] v);
    if (v > 44'sd524287) return 20'sh7FFFF;
    if (v < -44'sd524288) return 20'sh80000;
    return v[19:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [GLQ_PROD_W-1:0] v);
    if (v > 44'sd32767) return 16'sh7FFF;
    if (v < -44'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // floor((v + 2^(sh-1)) / 2^sh)
  function automatic logic signed [GLQ_PROD_W-1:0] rnd_shr(
    input logic signed [GLQ_PROD_W-1:0] v,
    input int unsigned                  sh
  );
    logic signed [GLQ_PROD_W-1:0] t;
    t = v + (44'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

endpackage

@@ design/glq_ram.sv @@
// glq_ram: generic single-write, single-read ram with registered read data
// no dependencies

module glq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/glq_ctrl.sv @@
// glq_ctrl: sequencer for glyph_quad_layout; steps the shared multiplier and vertex beats
// depends on glq_pkg

module glq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_stall,
  input  glq_pkg::glq_sts_t sts,
  output glq_pkg::glq_cmd_t cmd
);

  import glq_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SCALE  = 14'b00000000000010,
    S_WAIT   = 14'b00000000000100,
    S_ASC    = 14'b00000000001000,
    S_LOOKUP = 14'b00000000010000,
    S_YO     = 14'b00000000100000,
    S_W      = 14'b00000001000000,
    S_H      = 14'b00000010000000,
    S_ADV    = 14'b00000100000000,
    S_NX0    = 14'b00001000000000,
    S_NX1    = 14'b00010000000000,
    S_NY0    = 14'b00100000000000,
    S_NY1    = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] vtx_r, vtx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vtx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      vtx_r   <= vtx_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    vtx_nxt      = vtx_r;
    cmd.accept   = 1'b0;
    cmd.op       = OP_NONE;
    cmd.miss_adv = 1'b0;
    cmd.emit     = 1'b0;
    cmd.vtx      = vtx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_cmd)
            CMD_START: state_nxt = S_SCALE;
            CMD_CHAR:  state_nxt = S_LOOKUP;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_ASC;
      S_ASC: begin
        cmd.op    = OP_ASC;
        state_nxt = S_IDLE;
      end
      S_LOOKUP: begin
        if (!sts.found) begin
          cmd.miss_adv = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.empty) begin
          cmd.op    = OP_ADV;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_XO;
          state_nxt = S_YO;
        end
      end
      S_YO: begin
        cmd.op    = OP_YO;
        state_nxt = S_W;
      end
      S_W: begin
        cmd.op    = OP_W;
        state_nxt = S_H;
      end
      S_H: begin
        cmd.op    = OP_H;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        cmd.op    = OP_ADV;
        state_nxt = S_NX0;
      end
      S_NX0: begin
        cmd.op    = OP_NX0;
        state_nxt = S_NX1;
      end
      S_NX1: begin
        cmd.op    = OP_NX1;
        state_nxt = S_NY0;
      end
      S_NY0: begin
        cmd.op    = OP_NY0;
        state_nxt = S_NY1;
      end
      S_NY1: begin
        cmd.op    = OP_NY1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          vtx_nxt  = vtx_r + 2'd1;
          if (vtx_r == 2'd3) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        vtx_nxt   = 2'd0;
      end
    endcase
  end

endmodule

@@ design/glq_dp.sv @@
// glq_dp: datapath of glyph_quad_layout: config registers, glyph table, pen state,
// shared multiplier with write-back, quad corners and output register; depends on glq_pkg, glq_ram

module glq_dp #(
  parameter int GLYPH_ENTRIES = glq_pkg::GLQ_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  glq_pkg::cfg_idx_t               cfg_index,
  input  logic [glq_pkg::GLQ_CFG_W-1:0]   cfg_data,
  input  glq_pkg::glq_in_t                in_item,
  input  glq_pkg::glq_cmd_t               cmd,
  output glq_pkg::glq_sts_t               sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output glq_pkg::glq_out_t               out_item
);

  import glq_pkg::*;

  localparam int          AW      = $clog2(GLYPH_ENTRIES);
  localparam logic [8:0]  ENT_LIM = 9'(GLYPH_ENTRIES);
  localparam logic        FB_OK   = (GLQ_FALLBACK_CODE < GLYPH_ENTRIES);
  localparam logic [AW-1:0] FB_IDX = AW'(FB_OK ? GLQ_FALLBACK_CODE : 0);

  // configuration
  logic        [16:0] inv_em_r, inv_em_nxt;
  logic signed [15:0] asc_r, asc_nxt;
  logic        [16:0] ndcx_r, ndcx_nxt;
  logic        [16:0] ndcy_r, ndcy_nxt;

  // string state
  logic signed [19:0] pen_r, pen_nxt;
  logic signed [19:0] base_r, base_nxt;
  logic        [20:0] scale_r, scale_nxt;
  logic        [11:0] half_r, half_nxt;
  logic        [31:0] color_r, color_nxt;
  logic        [15:0] vcount_r, vcount_nxt;
  logic signed [19:0] sy_r, sy_nxt;
  logic        [11:0] size_r, size_nxt;

  // glyph lookup
  logic [GLYPH_ENTRIES-1:0] valid_r, valid_nxt;
  logic                     found_r, found_nxt;
  logic                     is_load, is_char, in_range, hit, fb_hit, ram_we;
  logic [AW-1:0]            code_idx, raddr;
  glq_glyph_t               wr_ent, rd_ent;
  logic [$bits(glq_glyph_t)-1:0] rdata;

  // multiplier and corners
  logic signed [GLQ_MUL_W-1:0]  mul_a, mul_b;
  logic signed [GLQ_PROD_W-1:0] prod_r, prod_nxt;
  op_t                          op_r;
  logic signed [GLQ_PROD_W-1:0] r12, r6, sc_tmp;
  logic signed [19:0] x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic signed [15:0] nx0_r, nx0_nxt, nx1_r, nx1_nxt, ny0_r, ny0_nxt, ny1_r, ny1_nxt;

  // output register
  logic     out_valid_r, out_valid_nxt;
  glq_out_t out_r, out_nxt;

  assign is_load  = cmd.accept && (in_item.cmd == CMD_LOAD);
  assign is_char  = cmd.accept && (in_item.cmd == CMD_CHAR);
  assign in_range = !in_item.code[7] && ({1'b0, in_item.code} < ENT_LIM);
  assign code_idx = in_item.code[AW-1:0];
  assign hit      = in_range && valid_r[code_idx];
  assign fb_hit   = FB_OK && valid_r[FB_IDX];
  assign raddr    = hit ? code_idx : FB_IDX;
  assign ram_we   = is_load && in_range;

  always_comb begin
    wr_ent.advance = in_item.advance;
    wr_ent.xoffset = in_item.xoffset;
    wr_ent.yoffset = in_item.yoffset;
    wr_ent.width   = in_item.width;
    wr_ent.height  = in_item.height;
    wr_ent.uv_rect = in_item.uv_rect;
  end

  glq_ram #(
    .WIDTH($bits(glq_glyph_t)),
    .DEPTH(GLYPH_ENTRIES)
  ) u_glyph_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(code_idx),
    .wdata(wr_ent),
    .re   (is_char),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_ent = glq_glyph_t'(rdata);

  assign sts.found    = found_r;
  assign sts.empty    = (rd_ent.width == 15'd0) || (rd_ent.height == 15'd0);
  assign sts.out_free = !out_valid_r || !out_stall;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SCALE: begin
        mul_a = {10'd0, size_r};
        mul_b = {5'd0, inv_em_r};
      end
      OP_ASC: begin
        mul_a = GLQ_MUL_W'(asc_r);
        mul_b = {1'b0, scale_r};
      end
      OP_XO: begin
        mul_a = GLQ_MUL_W'(rd_ent.xoffset);
        mul_b = {1'b0, scale_r};
      end
      OP_YO: begin
        mul_a = GLQ_MUL_W'(rd_ent.yoffset);
        mul_b = {1'b0, scale_r};
      end
      OP_W: begin
        mul_a = {7'd0, rd_ent.width};
        mul_b = {1'b0, scale_r};
      end
      OP_H: begin
        mul_a = {7'd0, rd_ent.height};
        mul_b = {1'b0, scale_r};
      end
      OP_ADV: begin
        mul_a = GLQ_MUL_W'(rd_ent.advance);
        mul_b = {1'b0, scale_r};
      end
      OP_NX0: begin
        mul_a = GLQ_MUL_W'(x0_r);
        mul_b = {5'd0, ndcx_r};
      end
      OP_NX1: begin
        mul_a = GLQ_MUL_W'(x1_r);
        mul_b = {5'd0, ndcx_r};
      end
      OP_NY0: begin
        mul_a = GLQ_MUL_W'(y0_r);
        mul_b = {5'd0, ndcy_r};
      end
      OP_NY1: begin
        mul_a = GLQ_MUL_W'(y1_r);
        mul_b = {5'd0, ndcy_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  assign r12    = rnd_shr(prod_r, 12);
  assign r6     = rnd_shr(prod_r, 6);
  assign sc_tmp = prod_r + 44'sd128;

  // write-back, item intake and vertex beats
  always_comb begin
    inv_em_nxt    = inv_em_r;
    asc_nxt       = asc_r;
    ndcx_nxt      = ndcx_r;
    ndcy_nxt      = ndcy_r;
    pen_nxt       = pen_r;
    base_nxt      = base_r;
    scale_nxt     = scale_r;
    half_nxt      = half_r;
    color_nxt     = color_r;
    vcount_nxt    = vcount_r;
    sy_nxt        = sy_r;
    size_nxt      = size_r;
    valid_nxt     = valid_r;
    found_nxt     = found_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    nx0_nxt       = nx0_r;
    nx1_nxt       = nx1_r;
    ny0_nxt       = ny0_r;
    ny1_nxt       = ny1_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_INV_EM:   inv_em_nxt = cfg_data;
        CFG_ASCENDER: asc_nxt    = cfg_data[15:0];
        CFG_NDC_X:    ndcx_nxt   = cfg_data;
        CFG_NDC_Y:    ndcy_nxt   = cfg_data;
        default:      inv_em_nxt = inv_em_r;
      endcase
    end

    case (op_r)
      OP_SCALE: scale_nxt = sc_tmp[28:8];
      OP_ASC:   base_nxt  = sat20(GLQ_PROD_W'(sy_r) + r12);
      OP_XO:    x0_nxt    = sat20(GLQ_PROD_W'(pen_r) + r12);
      OP_YO:    y0_nxt    = sat20(GLQ_PROD_W'(base_r) - r12);
      OP_W:     x1_nxt    = sat20(GLQ_PROD_W'(x0_r) + r12);
      OP_H:     y1_nxt    = sat20(GLQ_PROD_W'(y0_r) + r12);
      OP_ADV:   pen_nxt   = sat20(GLQ_PROD_W'(pen_r) + r12);
      OP_NX0:   nx0_nxt   = sat16(r6 - GLQ_NDC_ONE);
      OP_NX1:   nx1_nxt   = sat16(r6 - GLQ_NDC_ONE);
      OP_NY0:   ny0_nxt   = sat16(GLQ_NDC_ONE - r6);
      OP_NY1:   ny1_nxt   = sat16(GLQ_NDC_ONE - r6);
      default:  scale_nxt = scale_r;
    endcase

    if (cmd.miss_adv) begin
      pen_nxt = sat20(GLQ_PROD_W'(pen_r) + $signed({32'd0, half_r}));
    end

    if (ram_we) begin
      valid_nxt[code_idx] = 1'b1;
    end
    if (is_char) begin
      found_nxt = hit || fb_hit;
    end

    // a new string overrides a late pen write-back from the glyph before it
    if (cmd.accept && (in_item.cmd == CMD_START)) begin
      pen_nxt    = in_item.start_x;
      sy_nxt     = in_item.start_y;
      size_nxt   = in_item.size;
      half_nxt   = 12'((13'(in_item.size) + 13'd1) >> 1);
      color_nxt  = in_item.color;
      vcount_nxt = 16'd0;
    end

    if (cmd.emit) begin
      out_valid_nxt        = 1'b1;
      out_nxt.vertex_color = color_r;
      out_nxt.vertex_index = vcount_r;
      vcount_nxt           = vcount_r + 16'd1;
      case (cmd.vtx)
        2'd0: begin
          out_nxt.x_ndc = nx0_r;
          out_nxt.y_ndc = ny0_r;
          out_nxt.tex_u = rd_ent.uv_rect[15:0];
          out_nxt.tex_v = rd_ent.uv_rect[31:16];
          out_nxt.last  = 1'b0;
        end
        2'd1: begin
          out_nxt.x_ndc = nx1_r;
          out_nxt.y_ndc = ny0_r;
          out_nxt.tex_u = rd_ent.uv_rect[47:32];
          out_nxt.tex_v = rd_ent.uv_rect[31:16];
          out_nxt.last  = 1'b0;
        end
        2'd2: begin
          out_nxt.x_ndc = nx1_r;
          out_nxt.y_ndc = ny1_r;
          out_nxt.tex_u = rd_ent.uv_rect[47:32];
          out_nxt.tex_v = rd_ent.uv_rect[63:48];
          out_nxt.last  = 1'b0;
        end
        default: begin
          out_nxt.x_ndc = nx0_r;
          out_nxt.y_ndc = ny1_r;
          out_nxt.tex_u = rd_ent.uv_rect[15:0];
          out_nxt.tex_v = rd_ent.uv_rect[63:48];
          out_nxt.last  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_em_r    <= GLQ_INV_EM_RST;
      asc_r       <= GLQ_ASC_RST;
      ndcx_r      <= GLQ_NDC_X_RST;
      ndcy_r      <= GLQ_NDC_Y_RST;
      pen_r       <= '0;
      base_r      <= '0;
      scale_r     <= '0;
      half_r      <= '0;
      color_r     <= '0;
      vcount_r    <= '0;
      valid_r     <= '0;
      found_r     <= 1'b0;
      op_r        <= OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      inv_em_r    <= inv_em_nxt;
      asc_r       <= asc_nxt;
      ndcx_r      <= ndcx_nxt;
      ndcy_r      <= ndcy_nxt;
      pen_r       <= pen_nxt;
      base_r      <= base_nxt;
      scale_r     <= scale_nxt;
      half_r      <= half_nxt;
      color_r     <= color_nxt;
      vcount_r    <= vcount_nxt;
      valid_r     <= valid_nxt;
      found_r     <= found_nxt;
      op_r        <= cmd.op;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sy_r   <= sy_nxt;
    size_r <= size_nxt;
    prod_r <= prod_nxt;
    x0_r   <= x0_nxt;
    y0_r   <= y0_nxt;
    x1_r   <= x1_nxt;
    y1_r   <= y1_nxt;
    nx0_r  <= nx0_nxt;
    nx1_r  <= nx1_nxt;
    ny0_r  <= ny0_nxt;
    ny1_r  <= ny1_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> (out_r.vertex_index[1:0] == 2'b11))
    else $error("closing vertex of a quad off its four-vertex slot");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("vertex beat loaded over a stalled one");

  a_quad_found: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_XO) |-> (found_r && !sts.empty))
    else $error("quad started for a missing or empty glyph");
`endif

endmodule

@@ design/glyph_quad_layout.sv @@
// glyph_quad_layout: top level, bitmap font text quad layout in fixed point
// depends on glq_pkg, glq_ctrl, glq_dp (and glq_ram through glq_dp)

// A load item leaves the sequencer idle; a start item steps it through the scale,
// wait and ascender states, forming the text scale and the baseline on the shared
// 22x22 multiplier. A character whose glyph and fallback are both missing, or whose
// glyph is empty, is looked up on acceptance, then advances the pen. A visible
// glyph goes through the table read, nine products issued one per cycle on the
// single multiplier (edges, pen advance and the four screen coordinates), then four
// vertex beats through the output register, held while the result side stalls. The
// next item is accepted while the last vertex of a quad still waits to be taken.
// The glyph table holds GLYPH_ENTRIES entries with per-entry valid bits cleared by
// reset, so the block accepts items from the first cycle after reset.

module glyph_quad_layout #(
  parameter int GLYPH_ENTRIES = glq_pkg::GLQ_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  glq_pkg::cfg_idx_t             cfg_index,
  input  logic [glq_pkg::GLQ_CFG_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  glq_pkg::glq_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output glq_pkg::glq_out_t             out_item
);

  import glq_pkg::*;

  glq_cmd_t cmd;
  glq_sts_t sts;

  glq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_cmd  (in_item.cmd),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  glq_dp #(
    .GLYPH_ENTRIES(GLYPH_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
